// File: src/l1ac_pkg.sv
package l1ac_pkg;

  // Number formats: signals are signed, coefficients carry FRAC_W fraction bits.
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int COEF_W    = 25;
  localparam int PROD_W    = COEF_W + DATA_W;
  localparam int RND_W     = PROD_W - FRAC_W;
  localparam int STEP_W    = 4;
  localparam int CFG_IDX_W = 3;

  // Widths of the configuration registers.
  localparam int MPOLE_W = 17;
  localparam int BGAIN_W = 24;
  localparam int AGAIN_W = 23;
  localparam int FPOLE_W = 16;
  localparam int RGAIN_W = 24;
  localparam int ELIM_W  = 31;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_POLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODEL_INPUT_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_GAIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_POLE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_GAIN         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ESTIMATE_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX        = 3'd7;

  typedef logic [STEP_W-1:0] step_t;

  // Microcode addresses, one per step of the sample program.
  localparam step_t ST_IDLE      = 4'd0;
  localparam step_t ST_ERR       = 4'd1;
  localparam step_t ST_MUL_ADAPT = 4'd2;
  localparam step_t ST_SAVE_M5   = 4'd3;
  localparam step_t ST_SIG_SUB   = 4'd4;
  localparam step_t ST_SIG_CLAMP = 4'd5;
  localparam step_t ST_FILT_IN   = 4'd6;
  localparam step_t ST_MUL_W     = 4'd7;
  localparam step_t ST_SAVE_M3   = 4'd8;
  localparam step_t ST_FILT      = 4'd9;
  localparam step_t ST_DRIVE     = 4'd10;
  localparam step_t ST_MODEL_IN  = 4'd11;
  localparam step_t ST_MUL_BM    = 4'd12;
  localparam step_t ST_MUL_WAIT  = 4'd13;
  localparam step_t ST_PREDICT   = 4'd14;
  localparam step_t ST_OUT       = 4'd15;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_NO_INPUT,
    JMP_OUT_BUSY
  } jmp_e;

  typedef enum logic [2:0] {
    CF_ADAPT,
    CF_REF,
    CF_FPOLE,
    CF_FWEIGHT,
    CF_MPOLE,
    CF_BGAIN
  } coef_e;

  typedef enum logic [3:0] {
    SR_Y,
    SR_R,
    SR_ERR,
    SR_SIG,
    SR_FLT,
    SR_PRD,
    SR_TMP,
    SR_HA,
    SR_HB,
    SR_U,
    SR_RND
  } src_e;

  typedef enum logic [2:0] {
    AL_ADD,
    AL_SUB,
    AL_PASS,
    AL_CLP_EST,
    AL_CLP_DRV
  } alu_e;

  typedef enum logic [3:0] {
    DS_NONE,
    DS_ERR,
    DS_SIG,
    DS_FLT,
    DS_PRD,
    DS_TMP,
    DS_HA,
    DS_HB,
    DS_U
  } dst_e;

  // One microcode control word.
  typedef struct packed {
    jmp_e  jmp;
    step_t target;
    logic  mul_en;
    coef_e coef;
    src_e  mul_src;
    alu_e  op;
    src_e  x_src;
    src_e  y_src;
    dst_e  dst;
    logic  out_load;
  } ctl_t;

  // Configuration register file contents.
  typedef struct packed {
    logic signed [MPOLE_W-1:0] model_pole;
    logic signed [BGAIN_W-1:0] model_input_gain;
    logic        [AGAIN_W-1:0] adapt_gain;
    logic        [FPOLE_W-1:0] filter_pole;
    logic signed [RGAIN_W-1:0] ref_gain;
    logic        [ELIM_W-1:0]  estimate_limit;
    logic signed [DATA_W-1:0]  drive_min;
    logic signed [DATA_W-1:0]  drive_max;
  } cfg_t;

endpackage

// File: src/l1_adaptive_control_step_top.sv
// One sample of a first-order L1 adaptive controller in Q16.16 fixed point. Each input
// beat (measurement, reference) runs a 16-step microcode program on one shared 25x32
// multiplier and one saturating adder. The result enters the output register at the
// last step of the program, and the next input beat is taken once the program is back
// at idle; no new beat is taken while a sample's program runs. The multiplier's
// issue-to-rounded-result latency sets the program length. A result waiting in the
// output register does not block acceptance of the next input beat; the next sample's
// program then holds at its last step until that result leaves.
// Configuration registers are written through the plain write port; the user must
// write them only while no sample is in flight, as the block itself does not enforce this.
module l1_adaptive_control_step_top
  import l1ac_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [DATA_W-1:0]    measurement_i,
  input  logic signed [DATA_W-1:0]    reference_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [DATA_W-1:0]    drive_o,
  output logic signed [DATA_W-1:0]    prediction_error_o,
  output logic signed [DATA_W-1:0]    disturbance_estimate_o,
  input  logic                        cfg_we_i,
  input  logic        [CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [DATA_W-1:0]    cfg_data_i
);

  step_t pc_q, pc_d;
  ctl_t  ctl;
  cfg_t  cfg_q;
  logic  jump, out_busy, in_fire, out_load;
  logic  out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] dp_drive, dp_err, dp_est;
  logic signed [DATA_W-1:0] drive_q, err_q, est_q;

  l1ac_ucode_rom u_rom (
    .pc_i  (pc_q),
    .ctl_o (ctl)
  );

  l1ac_datapath u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .ctl_i                  (ctl),
    .cfg_i                  (cfg_q),
    .in_load_i              (in_fire),
    .measurement_i          (measurement_i),
    .reference_i            (reference_i),
    .drive_o                (dp_drive),
    .prediction_error_o     (dp_err),
    .disturbance_estimate_o (dp_est)
  );

  // Step counter with conditional jumps.
  assign in_stall_o = (pc_q != ST_IDLE);
  assign in_fire    = in_valid_i && (pc_q == ST_IDLE);
  assign out_busy   = out_valid_q && out_stall_i;

  always_comb begin
    unique case (ctl.jmp)
      JMP_NONE:     jump = 1'b0;
      JMP_NO_INPUT: jump = !in_valid_i;
      JMP_OUT_BUSY: jump = out_busy;
      default:      jump = 1'b0;
    endcase
    pc_d = jump ? ctl.target : pc_q + step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  // Output register: loaded when the program finishes and the previous beat is gone.
  assign out_load = ctl.out_load && !out_busy;

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      drive_q <= dp_drive;
      err_q   <= dp_err;
      est_q   <= dp_est;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign drive_o                = drive_q;
  assign prediction_error_o     = err_q;
  assign disturbance_estimate_o = est_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.model_pole       <= '0;
      cfg_q.model_input_gain <= BGAIN_W'(65536);
      cfg_q.adapt_gain       <= AGAIN_W'(65536);
      cfg_q.filter_pole      <= FPOLE_W'(32768);
      cfg_q.ref_gain         <= RGAIN_W'(65536);
      cfg_q.estimate_limit   <= '1;
      cfg_q.drive_min        <= {1'b1, {(DATA_W-1){1'b0}}};
      cfg_q.drive_max        <= {1'b0, {(DATA_W-1){1'b1}}};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODEL_POLE:       cfg_q.model_pole       <= cfg_data_i[MPOLE_W-1:0];
        CFG_MODEL_INPUT_GAIN: cfg_q.model_input_gain <= cfg_data_i[BGAIN_W-1:0];
        CFG_ADAPT_GAIN:       cfg_q.adapt_gain       <= cfg_data_i[AGAIN_W-1:0];
        CFG_FILTER_POLE:      cfg_q.filter_pole      <= cfg_data_i[FPOLE_W-1:0];
        CFG_REF_GAIN:         cfg_q.ref_gain         <= cfg_data_i[RGAIN_W-1:0];
        CFG_ESTIMATE_LIMIT:   cfg_q.estimate_limit   <= cfg_data_i[ELIM_W-1:0];
        CFG_DRIVE_MIN:        cfg_q.drive_min        <= cfg_data_i;
        CFG_DRIVE_MAX:        cfg_q.drive_max        <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// File: src/l1ac_ucode_rom.sv
module l1ac_ucode_rom
  import l1ac_pkg::*;
(
  input  step_t pc_i,
  output ctl_t  ctl_o
);

  // Program for one sample. Products pass the product and rounding registers.
  always_comb begin
    ctl_o = '{jmp: JMP_NONE, target: ST_IDLE, mul_en: 1'b0, coef: CF_ADAPT,
              mul_src: SR_ERR, op: AL_PASS, x_src: SR_RND, y_src: SR_RND,
              dst: DS_NONE, out_load: 1'b0};
    unique case (pc_i)
      ST_IDLE: begin
        ctl_o.jmp    = JMP_NO_INPUT;
        ctl_o.target = ST_IDLE;
      end
      ST_ERR: begin
        // Prediction error, and the model pole term on the old predicted state.
        ctl_o.op      = AL_SUB;
        ctl_o.x_src   = SR_PRD;
        ctl_o.y_src   = SR_Y;
        ctl_o.dst     = DS_ERR;
        ctl_o.mul_en  = 1'b1;
        ctl_o.coef    = CF_MPOLE;
        ctl_o.mul_src = SR_PRD;
      end
      ST_MUL_ADAPT: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.coef    = CF_ADAPT;
        ctl_o.mul_src = SR_ERR;
      end
      ST_SAVE_M5: begin
        ctl_o.op      = AL_PASS;
        ctl_o.x_src   = SR_RND;
        ctl_o.dst     = DS_HA;
        ctl_o.mul_en  = 1'b1;
        ctl_o.coef    = CF_REF;
        ctl_o.mul_src = SR_R;
      end
      ST_SIG_SUB: begin
        ctl_o.op    = AL_SUB;
        ctl_o.x_src = SR_SIG;
        ctl_o.y_src = SR_RND;
        ctl_o.dst   = DS_SIG;
      end
      ST_SIG_CLAMP: begin
        ctl_o.op    = AL_CLP_EST;
        ctl_o.x_src = SR_SIG;
        ctl_o.dst   = DS_SIG;
      end
      ST_FILT_IN: begin
        // Feedforward reference minus estimate; filter feedback product starts.
        ctl_o.op      = AL_SUB;
        ctl_o.x_src   = SR_RND;
        ctl_o.y_src   = SR_SIG;
        ctl_o.dst     = DS_TMP;
        ctl_o.mul_en  = 1'b1;
        ctl_o.coef    = CF_FPOLE;
        ctl_o.mul_src = SR_FLT;
      end
      ST_MUL_W: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.coef    = CF_FWEIGHT;
        ctl_o.mul_src = SR_TMP;
      end
      ST_SAVE_M3: begin
        ctl_o.op    = AL_PASS;
        ctl_o.x_src = SR_RND;
        ctl_o.dst   = DS_HB;
      end
      ST_FILT: begin
        ctl_o.op    = AL_ADD;
        ctl_o.x_src = SR_HB;
        ctl_o.y_src = SR_RND;
        ctl_o.dst   = DS_FLT;
      end
      ST_DRIVE: begin
        ctl_o.op    = AL_CLP_DRV;
        ctl_o.x_src = SR_FLT;
        ctl_o.dst   = DS_U;
      end
      ST_MODEL_IN: begin
        ctl_o.op    = AL_ADD;
        ctl_o.x_src = SR_U;
        ctl_o.y_src = SR_SIG;
        ctl_o.dst   = DS_TMP;
      end
      ST_MUL_BM: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.coef    = CF_BGAIN;
        ctl_o.mul_src = SR_TMP;
      end
      ST_MUL_WAIT: begin
        ctl_o.dst = DS_NONE;
      end
      ST_PREDICT: begin
        ctl_o.op    = AL_ADD;
        ctl_o.x_src = SR_HA;
        ctl_o.y_src = SR_RND;
        ctl_o.dst   = DS_PRD;
      end
      ST_OUT: begin
        // Hold here while the previous result still sits in the output register.
        ctl_o.jmp      = JMP_OUT_BUSY;
        ctl_o.target   = ST_OUT;
        ctl_o.out_load = 1'b1;
      end
    endcase
  end

endmodule

// File: src/l1ac_datapath.sv
module l1ac_datapath
  import l1ac_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctl_t                     ctl_i,
  input  cfg_t                     cfg_i,
  input  logic                     in_load_i,
  input  logic signed [DATA_W-1:0] measurement_i,
  input  logic signed [DATA_W-1:0] reference_i,
  output logic signed [DATA_W-1:0] drive_o,
  output logic signed [DATA_W-1:0] prediction_error_o,
  output logic signed [DATA_W-1:0] disturbance_estimate_o
);

  localparam logic signed [DATA_W-1:0] SIG_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SIG_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] HALF    = PROD_W'(1) <<< (FRAC_W - 1);

  logic signed [DATA_W-1:0] y_q, r_q, err_q, sig_q, flt_q, prd_q;
  logic signed [DATA_W-1:0] tmp_q, ha_q, hb_q, u_q, rnd_q, rnd_d;
  logic signed [PROD_W-1:0] prod_q, prod_d, prod_adj;
  logic signed [RND_W-1:0]  prod_shr;
  logic signed [COEF_W-1:0] coef;
  logic        [FPOLE_W:0]  fweight;
  logic signed [DATA_W-1:0] mul_b, alu_x, alu_y, alu_res;
  logic signed [DATA_W:0]   sum_w, diff_w, lim_pos, lim_neg, x_w;
  logic                     rnd_in_range;

  // Register operand selection shared by the multiplier and both ALU ports.
  function automatic logic signed [DATA_W-1:0] pick(input src_e s);
    logic signed [DATA_W-1:0] v;
    unique case (s)
      SR_Y:    v = y_q;
      SR_R:    v = r_q;
      SR_ERR:  v = err_q;
      SR_SIG:  v = sig_q;
      SR_FLT:  v = flt_q;
      SR_PRD:  v = prd_q;
      SR_TMP:  v = tmp_q;
      SR_HA:   v = ha_q;
      SR_HB:   v = hb_q;
      SR_U:    v = u_q;
      SR_RND:  v = rnd_q;
      default: v = rnd_q;
    endcase
    return v;
  endfunction

  // Saturate a one-bit-grown sum back to the signal width.
  function automatic logic signed [DATA_W-1:0] sat1(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? SIG_MIN : SIG_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Coefficient selection; the filter input weight is one minus the pole.
  assign fweight = (FPOLE_W + 1)'(1 << FRAC_W) - {1'b0, cfg_i.filter_pole};

  always_comb begin
    unique case (ctl_i.coef)
      CF_ADAPT:   coef = $signed({{(COEF_W-AGAIN_W){1'b0}}, cfg_i.adapt_gain});
      CF_REF:     coef = $signed({{(COEF_W-RGAIN_W){cfg_i.ref_gain[RGAIN_W-1]}},
                                  cfg_i.ref_gain});
      CF_FPOLE:   coef = $signed({{(COEF_W-FPOLE_W){1'b0}}, cfg_i.filter_pole});
      CF_FWEIGHT: coef = $signed({{(COEF_W-FPOLE_W-1){1'b0}}, fweight});
      CF_MPOLE:   coef = $signed({{(COEF_W-MPOLE_W){cfg_i.model_pole[MPOLE_W-1]}},
                                  cfg_i.model_pole});
      CF_BGAIN:   coef = $signed({{(COEF_W-BGAIN_W){cfg_i.model_input_gain[BGAIN_W-1]}},
                                  cfg_i.model_input_gain});
      default:    coef = '0;
    endcase
  end

  // Shared multiplier, registered.
  always_comb mul_b = pick(ctl_i.mul_src);
  assign prod_d = PROD_W'(coef) * PROD_W'(mul_b);

  // Round to nearest with ties away from zero, then saturate; registered.
  assign prod_adj = prod_q + (prod_q[PROD_W-1] ? (HALF - PROD_W'(1)) : HALF);
  assign prod_shr = prod_adj[PROD_W-1:FRAC_W];
  assign rnd_in_range = (&prod_shr[RND_W-1:DATA_W-1]) | ~(|prod_shr[RND_W-1:DATA_W-1]);
  assign rnd_d = rnd_in_range ? prod_shr[DATA_W-1:0]
                              : (prod_shr[RND_W-1] ? SIG_MIN : SIG_MAX);

  // Saturating adder and the two clamps.
  always_comb alu_x = pick(ctl_i.x_src);
  always_comb alu_y = pick(ctl_i.y_src);
  assign x_w     = {alu_x[DATA_W-1], alu_x};
  assign sum_w   = x_w + {alu_y[DATA_W-1], alu_y};
  assign diff_w  = x_w - {alu_y[DATA_W-1], alu_y};
  assign lim_pos = $signed({2'b00, cfg_i.estimate_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    unique case (ctl_i.op)
      AL_ADD: alu_res = sat1(sum_w);
      AL_SUB: alu_res = sat1(diff_w);
      AL_PASS: alu_res = alu_x;
      AL_CLP_EST: begin
        if (x_w < lim_neg) begin
          alu_res = lim_neg[DATA_W-1:0];
        end else if (x_w > lim_pos) begin
          alu_res = lim_pos[DATA_W-1:0];
        end else begin
          alu_res = alu_x;
        end
      end
      AL_CLP_DRV: begin
        // With crossed limits the lower one wins for values below it.
        if (alu_x < cfg_i.drive_min) begin
          alu_res = cfg_i.drive_min;
        end else if (alu_x > cfg_i.drive_max) begin
          alu_res = cfg_i.drive_max;
        end else begin
          alu_res = alu_x;
        end
      end
      default: alu_res = alu_x;
    endcase
  end

  // Controller state registers, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q <= '0;
      flt_q <= '0;
      prd_q <= '0;
    end else begin
      if (ctl_i.dst == DS_SIG) begin
        sig_q <= alu_res;
      end
      if (ctl_i.dst == DS_FLT) begin
        flt_q <= alu_res;
      end
      if (ctl_i.dst == DS_PRD) begin
        prd_q <= alu_res;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      y_q <= measurement_i;
      r_q <= reference_i;
    end
    if (ctl_i.mul_en) begin
      prod_q <= prod_d;
    end
    rnd_q <= rnd_d;
    if (ctl_i.dst == DS_ERR) begin
      err_q <= alu_res;
    end
    if (ctl_i.dst == DS_TMP) begin
      tmp_q <= alu_res;
    end
    if (ctl_i.dst == DS_HA) begin
      ha_q <= alu_res;
    end
    if (ctl_i.dst == DS_HB) begin
      hb_q <= alu_res;
    end
    if (ctl_i.dst == DS_U) begin
      u_q <= alu_res;
    end
  end

  assign drive_o                = u_q;
  assign prediction_error_o     = err_q;
  assign disturbance_estimate_o = sig_q;

endmodule

// File: src/l1ac_checker.sv
module l1ac_checker
  import l1ac_pkg::*;
(
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic signed [DATA_W-1:0]    drive_o,
  input logic signed [DATA_W-1:0]    prediction_error_o,
  input logic signed [DATA_W-1:0]    disturbance_estimate_o
);

  logic in_beat;

  assign in_beat = in_valid_i && !in_stall_o;

  // The block is busy on the cycle after it takes a sample.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  // Every accepted sample has a result in the output register once its program has run.
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |-> ##16 out_valid_o)
    else $error("no result sixteen cycles after an accepted beat");

  // A new result only appears at the end of a sample's program, while input is stalled.
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a sample in flight");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_o) &&
      $stable(prediction_error_o) && $stable(disturbance_estimate_o))
    else $error("stalled result beat changed");

endmodule

bind l1_adaptive_control_step_top l1ac_checker u_l1ac_checker (.*);

// File: tb/tb_l1_adaptive_control_step_top.sv
`timescale 1ns / 100ps

module tb_l1_adaptive_control_step_top;
  import l1ac_pkg::*;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam longint SIG_MAX = 64'sd2147483647;
  localparam longint SIG_MIN = -SIG_MAX - 64'sd1;
  localparam int DRAIN_CYCLES = 16;

  // One expected output beat of the controller.
  typedef struct {
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] perr;
    logic signed [DATA_W-1:0] estimate;
  } loop_out_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic signed [DATA_W-1:0]    measurement_i;
  logic signed [DATA_W-1:0]    reference_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [DATA_W-1:0]    drive_o;
  logic signed [DATA_W-1:0]    prediction_error_o;
  logic signed [DATA_W-1:0]    disturbance_estimate_o;
  logic                        cfg_we_i;
  logic        [CFG_IDX_W-1:0] cfg_index_i;
  logic        [DATA_W-1:0]    cfg_data_i;

  // Shadow copy of the gain registers.
  logic signed [MPOLE_W-1:0] mdl_pole;
  logic signed [BGAIN_W-1:0] mdl_gain;
  logic        [AGAIN_W-1:0] adapt_k;
  logic        [FPOLE_W-1:0] lpf_pole;
  logic signed [RGAIN_W-1:0] fwd_gain;
  logic        [ELIM_W-1:0]  est_limit;
  logic signed [DATA_W-1:0]  drv_min;
  logic signed [DATA_W-1:0]  drv_max;

  // Shadow copy of the loop state.
  logic signed [DATA_W-1:0] x_hat;
  logic signed [DATA_W-1:0] sigma_hat;
  logic signed [DATA_W-1:0] lpf_out;

  loop_out_t pending_outputs[$];
  int        mismatch_count;
  bit        gap_en;
  bit        stall_en;

  l1_adaptive_control_step_top u_top (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .measurement_i          (measurement_i),
    .reference_i            (reference_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .drive_o                (drive_o),
    .prediction_error_o     (prediction_error_o),
    .disturbance_estimate_o (disturbance_estimate_o),
    .cfg_we_i               (cfg_we_i),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_l1_adaptive_control_step_top failed");
    $finish;
  end

  // Saturate to the signed signal range.
  function automatic longint sat_q(input longint v);
    if (v > SIG_MAX) return SIG_MAX;
    if (v < SIG_MIN) return SIG_MIN;
    return v;
  endfunction

  // Fixed-point product: rounded half away from zero, then saturated.
  function automatic longint mul_q(input longint a, input longint b);
    longint m;
    logic   neg;
    neg = (a < 0) != (b < 0);
    m = a * b;
    if (m < 0) m = -m;
    m = (m + 64'sd32768) >>> FRAC_W;
    if (neg) return (m > SIG_MAX + 1) ? SIG_MIN : -m;
    return (m > SIG_MAX) ? SIG_MAX : m;
  endfunction

  // Advance the shadow controller by one sample and return its outputs.
  function automatic loop_out_t predict_sample(input logic signed [DATA_W-1:0] meas,
                                               input logic signed [DATA_W-1:0] setp);
    longint    err;
    longint    sig;
    longint    lim;
    longint    fin;
    longint    w;
    longint    filt;
    longint    u;
    longint    x;
    loop_out_t o;
    err = sat_q(longint'(x_hat) - longint'(meas));
    sig = sat_q(longint'(sigma_hat) - mul_q(longint'(adapt_k), err));
    lim = longint'(est_limit);
    if (sig < -lim) sig = -lim;
    else if (sig > lim) sig = lim;
    fin = sat_q(mul_q(longint'(fwd_gain), longint'(setp)) - sig);
    w = (64'sd1 <<< FRAC_W) - longint'(lpf_pole);
    filt = sat_q(mul_q(longint'(lpf_pole), longint'(lpf_out)) + mul_q(w, fin));
    // Lower limit wins for values below it when the drive limits are crossed.
    if (filt < longint'(drv_min)) u = longint'(drv_min);
    else if (filt > longint'(drv_max)) u = longint'(drv_max);
    else u = filt;
    x = sat_q(mul_q(longint'(mdl_pole), longint'(x_hat)) +
              mul_q(longint'(mdl_gain), sat_q(u + sig)));
    sigma_hat = DATA_W'(sig);
    lpf_out = DATA_W'(filt);
    x_hat = DATA_W'(x);
    o.drive = DATA_W'(u);
    o.perr = DATA_W'(err);
    o.estimate = DATA_W'(sig);
    return o;
  endfunction

  function automatic int rand_sym(input int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  // Mix of extremes, full-range words and small values.
  function automatic logic signed [DATA_W-1:0] pick_signal();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3, 4: return $urandom();
      default: return rand_sym(10 << 16);
    endcase
  endfunction

  // Present one input beat, at times after a random gap, and wait until it is taken.
  task automatic send_sample(input logic signed [DATA_W-1:0] meas,
                             input logic signed [DATA_W-1:0] setp);
    if (gap_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    measurement_i <= meas;
    reference_i <= setp;
    do @(posedge clk_i); while (in_stall_o);
    pending_outputs.push_back(predict_sample(meas, setp));
  endtask

  // Stop sending and wait until the block has gone idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write; bits above the register width carry random junk at times.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    int                w;
    logic [DATA_W-1:0] data;
    case (idx)
      CFG_MODEL_POLE:       w = MPOLE_W;
      CFG_MODEL_INPUT_GAIN: w = BGAIN_W;
      CFG_ADAPT_GAIN:       w = AGAIN_W;
      CFG_FILTER_POLE:      w = FPOLE_W;
      CFG_REF_GAIN:         w = RGAIN_W;
      CFG_ESTIMATE_LIMIT:   w = ELIM_W;
      default:              w = DATA_W;
    endcase
    data = val;
    if (w < DATA_W && $urandom_range(0, 1) == 1) begin
      data = (val & ((32'h1 << w) - 32'h1)) | (32'($urandom()) << w);
    end
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_MODEL_POLE:       mdl_pole = data[MPOLE_W-1:0];
      CFG_MODEL_INPUT_GAIN: mdl_gain = data[BGAIN_W-1:0];
      CFG_ADAPT_GAIN:       adapt_k = data[AGAIN_W-1:0];
      CFG_FILTER_POLE:      lpf_pole = data[FPOLE_W-1:0];
      CFG_REF_GAIN:         fwd_gain = data[RGAIN_W-1:0];
      CFG_ESTIMATE_LIMIT:   est_limit = data[ELIM_W-1:0];
      CFG_DRIVE_MIN:        drv_min = data;
      CFG_DRIVE_MAX:        drv_max = data;
      default: ;
    endcase
  endtask

  // Load the whole gain set once the block is idle.
  task automatic program_gains(input logic [DATA_W-1:0] mp, input logic [DATA_W-1:0] bm,
                               input logic [DATA_W-1:0] ag, input logic [DATA_W-1:0] fp,
                               input logic [DATA_W-1:0] kg, input logic [DATA_W-1:0] el,
                               input logic [DATA_W-1:0] dn, input logic [DATA_W-1:0] dx);
    drain();
    write_reg(CFG_MODEL_POLE, mp);
    write_reg(CFG_MODEL_INPUT_GAIN, bm);
    write_reg(CFG_ADAPT_GAIN, ag);
    write_reg(CFG_FILTER_POLE, fp);
    write_reg(CFG_REF_GAIN, kg);
    write_reg(CFG_ESTIMATE_LIMIT, el);
    write_reg(CFG_DRIVE_MIN, dn);
    write_reg(CFG_DRIVE_MAX, dx);
    cfg_we_i <= 1'b0;
  endtask

  // Gain set drawn at random, with the extremes mixed in.
  task automatic program_random_gains();
    int mp;
    int bm;
    int ag;
    int fp;
    int kg;
    int el;
    int dn;
    int dx;
    case ($urandom_range(0, 5))
      0: mp = 65535;
      1: mp = -65535;
      2: mp = -65536;
      default: mp = rand_sym(65535);
    endcase
    case ($urandom_range(0, 5))
      0: bm = 8388607;
      1: bm = -8388608;
      2: bm = 0;
      default: bm = rand_sym(2 << 16);
    endcase
    case ($urandom_range(0, 5))
      0: ag = 0;
      1: ag = 8388607;
      default: ag = $urandom_range(1, 1 << 16);
    endcase
    case ($urandom_range(0, 5))
      0: fp = 0;
      1: fp = 65535;
      default: fp = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 5))
      0: kg = 8388607;
      1: kg = -8388608;
      default: kg = rand_sym(2 << 16);
    endcase
    case ($urandom_range(0, 5))
      0: el = 0;
      1: el = 32'h7fff_ffff;
      2: el = $urandom();
      default: el = $urandom_range(0, 100 << 16);
    endcase
    case ($urandom_range(0, 5))
      0: begin
        dn = $urandom();
        dx = $urandom();
      end
      1: begin
        dn = Q_MIN;
        dx = Q_MAX;
      end
      2: begin
        dn = $urandom_range(1, 10 << 16);
        dx = -dn;
      end
      default: begin
        dn = -int'($urandom_range(0, 20 << 16));
        dx = $urandom_range(0, 20 << 16);
      end
    endcase
    program_gains(mp, bm, ag, fp, kg, el, dn, dx);
  endtask

  task automatic test_reset_values();
    send_sample('0, '0);
    send_sample(Q_MAX, Q_MAX);
    send_sample(Q_MIN, Q_MIN);
    send_sample(Q_MAX, Q_MIN);
    send_sample(Q_MIN, Q_MAX);
    send_sample(-1, 1);
    send_sample(1 << 16, 3 << 16);
    send_sample($urandom(), $urandom());
  endtask

  // Lower limit above the upper one.
  task automatic test_crossed_drive_limits();
    program_gains(58982, 65536, 16384, 40000, 65536, 10 << 16, 3 << 16, -(3 << 16));
    send_sample('0, 5 << 16);
    send_sample(1 << 16, -(5 << 16));
    send_sample(-(1 << 16), 4 << 16);
    send_sample(Q_MAX, '0);
  endtask

  // Estimate only clamps, never adapts.
  task automatic test_zero_adaptation();
    program_gains(32768, 65536, 0, 32768, 65536, 2 << 16, Q_MIN, Q_MAX);
    send_sample(7 << 16, 1 << 16);
    send_sample(Q_MIN, 2 << 16);
    send_sample(-(7 << 16), Q_MAX);
  endtask

  task automatic test_coefficient_extremes();
    // Pole of magnitude one, zero model gain, zero estimate limit, equal drive limits.
    program_gains(-65536, 0, 8388607, 0, 8388607, 0, 32'h100, 32'h100);
    send_sample(Q_MAX, Q_MAX);
    send_sample(Q_MIN, 1 << 16);
    send_sample(3 << 16, Q_MIN);
    send_sample('0, '0);
    // Opposite extremes of every coefficient.
    program_gains(65535, -8388608, 1, 65535, -8388608, 32'h7fff_ffff, Q_MIN, Q_MAX);
    send_sample(Q_MIN, Q_MAX);
    send_sample(Q_MAX, Q_MIN);
    send_sample(5 << 16, 5 << 16);
    send_sample(-1, -1);
  endtask

  // Setpoint steps with a measurement that follows it, plus some wild beats.
  task automatic run_tracking(input int n);
    int sp;
    int ym;
    sp = rand_sym(8 << 16);
    ym = 0;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) sp = rand_sym(8 << 16);
      if ($urandom_range(0, 9) == 0) begin
        send_sample(pick_signal(), pick_signal());
      end else begin
        ym = ym + (sp - ym) / 8 + rand_sym(1 << 14);
        send_sample(ym, sp);
      end
    end
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 12; ph++) begin
      program_random_gains();
      run_tracking(105);
    end
  endtask

  // Back-to-back beats with no idling on either side.
  task automatic test_steady_run();
    program_gains(58982, 65536, 8192, 52000, 65536, 20 << 16, -(10 << 16), 10 << 16);
    gap_en = 1'b0;
    stall_en = 1'b0;
    run_tracking(150);
  endtask

  // Random stall bursts on the output side.
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_en && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic check_field(input string what, input logic signed [DATA_W-1:0] want,
                             input logic signed [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Compare every output beat against the oldest predicted sample.
  always @(posedge clk_i) begin : check_outputs
    loop_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: output beat with no sample pending, actual drive %0d error %0d est %0d",
                 $time, drive_o, prediction_error_o, disturbance_estimate_o);
        mismatch_count++;
      end else begin
        want = pending_outputs.pop_front();
        check_field("drive", want.drive, drive_o);
        check_field("prediction_error", want.perr, prediction_error_o);
        check_field("disturbance_estimate", want.estimate, disturbance_estimate_o);
      end
    end
  end

  initial begin
    mismatch_count = 0;
    gap_en = 1'b1;
    stall_en = 1'b1;
    mdl_pole = '0;
    mdl_gain = 24'sd65536;
    adapt_k = 23'd65536;
    lpf_pole = 16'd32768;
    fwd_gain = 24'sd65536;
    est_limit = 31'h7fff_ffff;
    drv_min = Q_MIN;
    drv_max = Q_MAX;
    x_hat = '0;
    sigma_hat = '0;
    lpf_out = '0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    measurement_i <= '0;
    reference_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_values();
    test_crossed_drive_limits();
    test_zero_adaptation();
    test_coefficient_extremes();
    test_random_phases();
    test_steady_run();

    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_l1_adaptive_control_step_top passed");
    end else begin
      $display("tb_l1_adaptive_control_step_top failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/l1ac_pkg.sv
src/l1ac_ucode_rom.sv
src/l1ac_datapath.sv
src/l1_adaptive_control_step_top.sv
src/l1ac_checker.sv
tb/tb_l1_adaptive_control_step_top.sv
